// File: rtl/first_char_histogram_selectivity_assert.svh
// assertion macros for the first-character histogram block
`ifndef FIRST_CHAR_HISTOGRAM_SELECTIVITY_ASSERT_SVH
`define FIRST_CHAR_HISTOGRAM_SELECTIVITY_ASSERT_SVH

`ifndef SYNTHESIS
`define FCHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define FCHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define FCHS_ASSERT(lbl, prop)
`define FCHS_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// File: rtl/fchs_pkg.sv
// shared types, microcode encodings and constants of the histogram block
package fchs_pkg;

  localparam int unsigned Q16_W = 16;
  localparam int unsigned SEL_W = 17;
  localparam int unsigned STEP_W = 5;

  localparam logic [SEL_W-1:0] Q16_ONE   = 17'd65536;
  localparam logic [SEL_W-1:0] FRAC_EQ   = 17'd3276;
  localparam logic [SEL_W-1:0] FRAC_NE   = 17'd62259;
  localparam logic [SEL_W-1:0] FRAC_LIKE = 17'd6553;

  localparam logic [2:0] CMP_GT   = 3'd0;
  localparam logic [2:0] CMP_GE   = 3'd1;
  localparam logic [2:0] CMP_LT   = 3'd2;
  localparam logic [2:0] CMP_LE   = 3'd3;
  localparam logic [2:0] CMP_EQ   = 3'd4;
  localparam logic [2:0] CMP_NE   = 3'd5;
  localparam logic [2:0] CMP_LIKE = 3'd6;

  localparam logic [1:0] LEN_EMPTY = 2'd0;
  localparam logic [1:0] LEN_ONE   = 2'd1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // program steps
  localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 5'd1;
  localparam logic [STEP_W-1:0] STEP_ADD_TOT  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_ADD_BIN  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_Q_INIT   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_Q_FIXED  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_Q_LEN    = 5'd6;
  localparam logic [STEP_W-1:0] STEP_WALK     = 5'd7;
  localparam logic [STEP_W-1:0] STEP_MUL      = 5'd8;
  localparam logic [STEP_W-1:0] STEP_DIV_BIN  = 5'd9;
  localparam logic [STEP_W-1:0] STEP_WAIT_BIN = 5'd10;
  localparam logic [STEP_W-1:0] STEP_ADD_QUOT = 5'd11;
  localparam logic [STEP_W-1:0] STEP_CLAMP    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_DIV_SEL  = 5'd13;
  localparam logic [STEP_W-1:0] STEP_WAIT_SEL = 5'd14;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 5'd15;
  localparam logic [STEP_W-1:0] STEP_DONE     = 5'd16;

  typedef struct packed {
    logic       operation;
    logic [1:0] value_length;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [2:0] compare_op;
  } in_t;

  typedef struct packed {
    logic [SEL_W-1:0] selectivity;
    logic             no_values;
  } out_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ADD_TOT,
    ACT_ADD_BIN,
    ACT_Q_INIT,
    ACT_WALK,
    ACT_MUL,
    ACT_DIV_BIN,
    ACT_ADD_QUOT,
    ACT_CLAMP,
    ACT_DIV_SEL,
    ACT_EMIT
  } act_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_IS_QUERY,
    COND_LEN_ZERO,
    COND_LEN_ONE,
    COND_TOTAL_ZERO,
    COND_CMP_FIXED,
    COND_IDX_LT_FB,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    act_e act;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic is_query;
    logic len_zero;
    logic len_one;
    logic total_zero;
    logic cmp_fixed;
    logic idx_lt_fb;
    logic div_busy;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/fchs_ram.sv
// generic single-write, single-read ram with registered read data
module fchs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fchs_div.sv
// restoring divider, one quotient bit per cycle
module fchs_div #(
  parameter int unsigned DVD_W = 48,
  parameter int unsigned DVS_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CNT_W'(DVD_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // keep the trial remainder when the subtraction borrows
      rem_d = diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ~diff[DVS_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

// File: rtl/fchs_seq.sv
// microcode sequencer: program rom, step counter and jump conditions
module fchs_seq
  import fchs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              hit;

  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] s);
    ucode_t w;
    w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    case (s)
      STEP_IDLE:     w = '{act: ACT_NOP,      cond: COND_NO_IN,      target: STEP_IDLE};
      STEP_DISPATCH: w = '{act: ACT_NOP,      cond: COND_IS_QUERY,   target: STEP_Q_INIT};
      STEP_ADD_TOT:  w = '{act: ACT_ADD_TOT,  cond: COND_LEN_ZERO,   target: STEP_IDLE};
      STEP_ADD_BIN:  w = '{act: ACT_ADD_BIN,  cond: COND_ALWAYS,     target: STEP_IDLE};
      STEP_Q_INIT:   w = '{act: ACT_Q_INIT,   cond: COND_TOTAL_ZERO, target: STEP_EMIT};
      STEP_Q_FIXED:  w = '{act: ACT_NOP,      cond: COND_CMP_FIXED,  target: STEP_EMIT};
      STEP_Q_LEN:    w = '{act: ACT_NOP,      cond: COND_LEN_ZERO,   target: STEP_CLAMP};
      STEP_WALK:     w = '{act: ACT_WALK,     cond: COND_IDX_LT_FB,  target: STEP_WALK};
      STEP_MUL:      w = '{act: ACT_MUL,      cond: COND_LEN_ONE,    target: STEP_CLAMP};
      STEP_DIV_BIN:  w = '{act: ACT_DIV_BIN,  cond: COND_NEVER,      target: STEP_IDLE};
      STEP_WAIT_BIN: w = '{act: ACT_NOP,      cond: COND_DIV_BUSY,   target: STEP_WAIT_BIN};
      STEP_ADD_QUOT: w = '{act: ACT_ADD_QUOT, cond: COND_NEVER,      target: STEP_IDLE};
      STEP_CLAMP:    w = '{act: ACT_CLAMP,    cond: COND_NEVER,      target: STEP_IDLE};
      STEP_DIV_SEL:  w = '{act: ACT_DIV_SEL,  cond: COND_NEVER,      target: STEP_IDLE};
      STEP_WAIT_SEL: w = '{act: ACT_NOP,      cond: COND_DIV_BUSY,   target: STEP_WAIT_SEL};
      STEP_EMIT:     w = '{act: ACT_EMIT,     cond: COND_OUT_BUSY,   target: STEP_EMIT};
      STEP_DONE:     w = '{act: ACT_NOP,      cond: COND_ALWAYS,     target: STEP_IDLE};
      default:       w = '{act: ACT_NOP,      cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  always_comb begin
    word = ucode_rom(step_q);
    case (word.cond)
      COND_NEVER:      hit = 1'b0;
      COND_ALWAYS:     hit = 1'b1;
      COND_NO_IN:      hit = !in_valid_i;
      COND_IS_QUERY:   hit = stat_i.is_query;
      COND_LEN_ZERO:   hit = stat_i.len_zero;
      COND_LEN_ONE:    hit = stat_i.len_one;
      COND_TOTAL_ZERO: hit = stat_i.total_zero;
      COND_CMP_FIXED:  hit = stat_i.cmp_fixed;
      COND_IDX_LT_FB:  hit = stat_i.idx_lt_fb;
      COND_DIV_BUSY:   hit = stat_i.div_busy;
      COND_OUT_BUSY:   hit = stat_i.out_busy;
      default:         hit = 1'b0;
    endcase
    step_d = hit ? word.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o  = (step_q == STEP_IDLE);
  assign ctrl_o.act  = word.act;
  assign ctrl_o.load = in_valid_i && in_ready_o;

endmodule

// File: rtl/fchs_dp.sv
// datapath: counters, bin memory, accumulator, multiplier, divider, output register
module fchs_dp
  import fchs_pkg::*;
#(
  parameter int unsigned BIN_COUNT       = 96,
  parameter int unsigned FIRST_CHAR_CODE = 32,
  parameter int unsigned COUNT_WIDTH     = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  in_t   in_data_i,
  input  logic  out_ready_i,
  output stat_t stat_o,
  output logic  out_valid_o,
  output out_t  out_data_o
);

  localparam int unsigned IDX_W  = $clog2(BIN_COUNT);
  localparam int unsigned ACC_W  = COUNT_WIDTH + 9;
  localparam int unsigned PROD_W = COUNT_WIDTH + IDX_W;
  localparam int unsigned DVD_W  = COUNT_WIDTH + Q16_W;
  localparam int unsigned DVS_W  = COUNT_WIDTH + 1;

  // split by bin count as a multiply by a scaled reciprocal, one 16-bit slice per cycle
  localparam int unsigned RCP_CH  = 16;
  localparam int unsigned RCP_NC  = (PROD_W + 2 + RCP_CH - 1) / RCP_CH;
  localparam int unsigned RCP_MW  = RCP_NC * RCP_CH;
  localparam int unsigned RCP_SH  = PROD_W + IDX_W;
  localparam int unsigned RCP_PW  = RCP_SH + 1;
  localparam int unsigned RCP_AW  = PROD_W + RCP_MW;
  localparam int unsigned RCP_PPW = PROD_W + RCP_CH;
  localparam int unsigned RCP_CW  = $clog2(RCP_NC + 1);

  localparam logic [COUNT_WIDTH-1:0] CntMax    = '1;
  localparam logic [8:0]             FirstCode = 9'(FIRST_CHAR_CODE);
  localparam logic [8:0]             LastBin   = 9'(BIN_COUNT - 1);
  localparam logic [RCP_SH:0]        RcpPow    = {1'b1, {RCP_SH{1'b0}}};
  localparam logic [RCP_SH:0]        RcpFull   = RcpPow / RCP_PW'(BIN_COUNT) + 1'b1;
  localparam logic [RCP_MW-1:0]      RcpMul    = RCP_MW'(RcpFull);

  function automatic logic [IDX_W-1:0] bin_of(logic [7:0] ch);
    logic [8:0] d;
    d = {1'b0, ch} - FirstCode;
    if ({1'b0, ch} < FirstCode) begin
      return '0;
    end else if (d > LastBin) begin
      return IDX_W'(LastBin);
    end else begin
      return d[IDX_W-1:0];
    end
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c);
    return (c == CntMax) ? c : c + 1'b1;
  endfunction

  in_t                    in_q, in_d;
  logic [COUNT_WIDTH-1:0] value_total_q, value_total_d;
  logic [COUNT_WIDTH-1:0] empty_total_q, empty_total_d;
  logic [BIN_COUNT-1:0]   vld_q, vld_d;
  logic                   rvld_q, rvld_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic                   nov_q, nov_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;
  logic [RCP_AW-1:0]      rcp_acc_q, rcp_acc_d;
  logic [RCP_MW-1:0]      rcp_mul_q, rcp_mul_d;
  logic [RCP_CW-1:0]      rcp_cnt_q, rcp_cnt_d;

  logic [IDX_W-1:0]       fb, sb, raddr;
  logic [COUNT_WIDTH-1:0] rdata, eff, acc_lo, num, rcp_quot;
  logic                   we, div_start, div_busy, out_busy, emit_fire, rcp_busy;
  logic [DVD_W-1:0]       dvd, quot;
  logic [DVS_W-1:0]       dvs;
  logic [SEL_W-1:0]       sel;
  logic [RCP_PPW-1:0]     rcp_pp;

  assign fb     = bin_of(in_q.first_char);
  assign sb     = bin_of(in_q.second_char);
  assign raddr  = (ctrl_i.act == ACT_WALK) ? idx_q : fb;
  // bins never written since reset read as zero
  assign eff    = rvld_q ? rdata : '0;
  assign we     = (ctrl_i.act == ACT_ADD_BIN);
  assign acc_lo = acc_q[COUNT_WIDTH-1:0];
  assign num    = (in_q.compare_op == CMP_LT || in_q.compare_op == CMP_LE) ?
                  acc_lo : value_total_q - acc_lo;

  assign div_start = (ctrl_i.act == ACT_DIV_SEL);
  assign dvd = {num, {Q16_W{1'b0}}};
  assign dvs = {1'b0, value_total_q};

  assign out_busy  = out_valid_q && !out_ready_i;
  assign emit_fire = (ctrl_i.act == ACT_EMIT) && !out_busy;

  assign rcp_busy = (rcp_cnt_q != '0);
  assign rcp_pp   = RCP_PPW'(prod_q) * RCP_PPW'(rcp_mul_q[RCP_MW-1 -: RCP_CH]);
  assign rcp_quot = rcp_acc_q[RCP_SH +: COUNT_WIDTH];

  fchs_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(BIN_COUNT)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fb),
    .wdata_i(sat_inc(eff)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  fchs_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  always_comb begin
    case (in_q.compare_op)
      CMP_GT, CMP_GE, CMP_LT, CMP_LE: sel = quot[SEL_W-1:0];
      CMP_EQ:   sel = FRAC_EQ;
      CMP_NE:   sel = FRAC_NE;
      CMP_LIKE: sel = FRAC_LIKE;
      default:  sel = '0;
    endcase
  end

  // most significant slice first, so the partial sum only ever shifts left
  always_comb begin
    rcp_acc_d = rcp_acc_q;
    rcp_mul_d = rcp_mul_q;
    rcp_cnt_d = rcp_cnt_q;
    if (ctrl_i.act == ACT_DIV_BIN) begin
      rcp_acc_d = '0;
      rcp_mul_d = RcpMul;
      rcp_cnt_d = RCP_CW'(RCP_NC);
    end else if (rcp_busy) begin
      rcp_acc_d = (rcp_acc_q << RCP_CH) + RCP_AW'(rcp_pp);
      rcp_mul_d = rcp_mul_q << RCP_CH;
      rcp_cnt_d = rcp_cnt_q - 1'b1;
    end
  end

  always_comb begin
    in_d          = in_q;
    value_total_d = value_total_q;
    empty_total_d = empty_total_q;
    vld_d         = vld_q;
    rvld_d        = vld_q[raddr];
    idx_d         = idx_q;
    pend_d        = pend_q;
    acc_d         = acc_q;
    prod_d        = prod_q;
    nov_d         = nov_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;

    if (ctrl_i.load) begin
      in_d = in_data_i;
    end

    case (ctrl_i.act)
      ACT_ADD_TOT: begin
        value_total_d = sat_inc(value_total_q);
        if (in_q.value_length == LEN_EMPTY) begin
          empty_total_d = sat_inc(empty_total_q);
        end
      end
      ACT_ADD_BIN: begin
        vld_d[fb] = 1'b1;
      end
      ACT_Q_INIT: begin
        acc_d  = ACC_W'(empty_total_q);
        idx_d  = '0;
        pend_d = 1'b0;
        nov_d  = (value_total_q == '0);
      end
      ACT_WALK: begin
        // read data arrives in the cycle after its address
        if (pend_q) begin
          acc_d = acc_q + ACC_W'(eff);
        end
        pend_d = (idx_q < fb);
        if (idx_q < fb) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ACT_MUL: begin
        prod_d = PROD_W'(sb) * PROD_W'(eff);
      end
      ACT_ADD_QUOT: begin
        acc_d = acc_q + ACC_W'(rcp_quot);
      end
      ACT_CLAMP: begin
        if (acc_q > ACC_W'(value_total_q)) begin
          acc_d = ACC_W'(value_total_q);
        end
      end
      ACT_EMIT: begin
        if (emit_fire) begin
          out_valid_d       = 1'b1;
          out_d.selectivity = nov_q ? '0 : sel;
          out_d.no_values   = nov_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_total_q <= '0;
      empty_total_q <= '0;
      vld_q         <= '0;
      rvld_q        <= 1'b0;
      pend_q        <= 1'b0;
      nov_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      rcp_cnt_q     <= '0;
    end else begin
      value_total_q <= value_total_d;
      empty_total_q <= empty_total_d;
      vld_q         <= vld_d;
      rvld_q        <= rvld_d;
      pend_q        <= pend_d;
      nov_q         <= nov_d;
      out_valid_q   <= out_valid_d;
      rcp_cnt_q     <= rcp_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    idx_q     <= idx_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    out_q     <= out_d;
    rcp_acc_q <= rcp_acc_d;
    rcp_mul_q <= rcp_mul_d;
  end

  assign stat_o.is_query   = (in_q.operation == OP_QUERY);
  assign stat_o.len_zero   = (in_q.value_length == LEN_EMPTY);
  assign stat_o.len_one    = (in_q.value_length == LEN_ONE);
  assign stat_o.total_zero = (value_total_q == '0);
  assign stat_o.cmp_fixed  = in_q.compare_op[2];
  assign stat_o.idx_lt_fb  = (idx_q < fb);
  assign stat_o.div_busy   = div_busy || rcp_busy;
  assign stat_o.out_busy   = out_busy;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/first_char_histogram_selectivity.sv
// top level of the first-character histogram and selectivity estimator
//
// input channel (in_valid_i/in_ready_o/in_data_i): one beat is either an add
// (operation 0) that counts a string into the histogram, or a query
// (operation 1) that asks for the fraction of counted strings matching a
// comparison. adds give no output beat; every query gives exactly one.
// output channel (out_valid_o/out_ready_i/out_data_o) carries a Q16
// selectivity and a no_values flag, held in an output register.
// a microcoded sequencer runs one item at a time; a new beat is taken only
// when the program is back at its idle step.
// query: the bin walk up to fb, the first-char bin (one memory read per bin),
// three partial products for the split by bin count and the bit-serial
// division by the total make up its work. one-char queries skip the split,
// empty-string queries skip the walk as well, and eq/ne/like/unknown and an
// empty histogram go straight to the result. reset clears all counters at
// once through per-bin valid bits.
// a stalled receiver holds the result; the next query waits at its emit
// step until the output register frees up.
`include "first_char_histogram_selectivity_assert.svh"

module first_char_histogram_selectivity
  import fchs_pkg::*;
#(
  parameter int unsigned BIN_COUNT       = 96,
  parameter int unsigned FIRST_CHAR_CODE = 32,
  parameter int unsigned COUNT_WIDTH     = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  fchs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .ctrl_o    (ctrl)
  );

  fchs_dp #(
    .BIN_COUNT      (BIN_COUNT),
    .FIRST_CHAR_CODE(FIRST_CHAR_CODE),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // a new result only ever comes from the emit step
  `FCHS_ASSERT_IMP(a_out_from_emit, $rose(out_valid_o), $past(ctrl.act == ACT_EMIT))
  // the fraction never exceeds one
  `FCHS_ASSERT_IMP(a_sel_range, out_valid_o, out_data_o.selectivity <= Q16_ONE)
  // an empty histogram reports zero
  `FCHS_ASSERT_IMP(a_nov_zero, out_valid_o && out_data_o.no_values, out_data_o.selectivity == '0)
  // the divider is done before a new beat can be taken
  `FCHS_ASSERT_IMP(a_idle_div, in_ready_o, !stat.div_busy)

endmodule

// File: dv/first_char_histogram_selectivity_checker.sv
`timescale 1ns / 100ps
// checker that watches both channels of the histogram block and compares estimates
module first_char_histogram_selectivity_checker
  import fchs_pkg::*;
#(
  parameter int unsigned BIN_COUNT       = 96,
  parameter int unsigned FIRST_CHAR_CODE = 32,
  parameter int unsigned COUNT_WIDTH     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t           COUNT_FULL = '1;
  localparam logic [SEL_W-1:0] SEL_EQ     = 17'd3276;
  localparam logic [SEL_W-1:0] SEL_NE     = 17'd62259;
  localparam logic [SEL_W-1:0] SEL_LIKE   = 17'd6553;

  count_t      bin_tally [BIN_COUNT];
  count_t      empty_tally;
  count_t      value_tally;
  out_t        estimate_q [$];
  int unsigned mismatches;

  function automatic int unsigned char_bin(logic [7:0] ch);
    int idx;
    idx = int'(ch) - int'(FIRST_CHAR_CODE);
    if (idx < 0) idx = 0;
    if (idx > int'(BIN_COUNT) - 1) idx = int'(BIN_COUNT) - 1;
    return idx;
  endfunction

  function automatic count_t bump(count_t c);
    return (c == COUNT_FULL) ? c : c + 1'b1;
  endfunction

  // counts an add into the histogram; a query returns 1 with its estimate
  function automatic bit histogram_step(input in_t beat, output out_t est);
    logic [63:0] below;
    logic [63:0] total;
    int unsigned fb;
    int unsigned i;
    est = '0;
    if (beat.operation == OP_ADD) begin
      value_tally = bump(value_tally);
      if (beat.value_length == LEN_EMPTY) begin
        empty_tally = bump(empty_tally);
      end else begin
        fb = char_bin(beat.first_char);
        bin_tally[fb] = bump(bin_tally[fb]);
      end
      return 1'b0;
    end
    if (value_tally == '0) begin
      est.no_values = 1'b1;
      return 1'b1;
    end
    total = 64'(value_tally);
    below = 64'(empty_tally);
    if (beat.value_length != LEN_EMPTY) begin
      fb = char_bin(beat.first_char);
      for (i = 0; i < fb; i++) below += 64'(bin_tally[i]);
      // partial share of the first-char bin from the second character
      if (beat.value_length != LEN_ONE)
        below += (64'(char_bin(beat.second_char)) * 64'(bin_tally[fb])) / BIN_COUNT;
    end
    if (below > total) below = total;
    case (beat.compare_op)
      CMP_GT, CMP_GE: est.selectivity = SEL_W'(((total - below) << 16) / total);
      CMP_LT, CMP_LE: est.selectivity = SEL_W'((below << 16) / total);
      CMP_EQ:         est.selectivity = SEL_EQ;
      CMP_NE:         est.selectivity = SEL_NE;
      CMP_LIKE:       est.selectivity = SEL_LIKE;
      default:        est.selectivity = '0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t est;
    out_t want;
    if (!rst_ni) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      empty_tally = '0;
      value_tally = '0;
      estimate_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (histogram_step(in_data_i, est)) estimate_q.push_back(est);
      end
      if (out_valid_i && out_ready_i) begin
        if (estimate_q.size() == 0) begin
          mismatches++;
          $error("result beat with no query waiting: selectivity %0d, no_values %0b",
                 out_data_i.selectivity, out_data_i.no_values);
        end else begin
          want = estimate_q.pop_front();
          if (out_data_i.selectivity !== want.selectivity) begin
            mismatches++;
            $error("selectivity: expected %0d, actual %0d",
                   want.selectivity, out_data_i.selectivity);
          end
          if (out_data_i.no_values !== want.no_values) begin
            mismatches++;
            $error("no_values: expected %0b, actual %0b",
                   want.no_values, out_data_i.no_values);
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= estimate_q.size();
  end

endmodule

// File: dv/first_char_histogram_selectivity_tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, beat stimulus and verdict for the histogram block
module first_char_histogram_selectivity_tb;
  import fchs_pkg::*;

  localparam logic [1:0]  LEN_TWO_PLUS = 2'd2;
  localparam logic [1:0]  LEN_CODE3    = 2'd3;
  localparam logic [2:0]  CMP_UNKNOWN  = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 528;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  int unsigned fail_count;
  int unsigned pending;
  bit          quiet_tx;

  always #5 clk_i = ~clk_i;

  first_char_histogram_selectivity i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  first_char_histogram_selectivity_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic in_t make_item(logic op, logic [1:0] len, logic [7:0] c1,
                                    logic [7:0] c2, logic [2:0] cmp);
    in_t it;
    it.operation    = op;
    it.value_length = len;
    it.first_char   = c1;
    it.second_char  = c2;
    it.compare_op   = cmp;
    return it;
  endfunction

  // mostly printable strings and ordered comparisons, some of everything else
  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    it.operation = ($urandom_range(0, 99) < 35) ? OP_QUERY : OP_ADD;
    pick = $urandom_range(0, 9);
    if (pick == 0) it.value_length = LEN_EMPTY;
    else if (pick < 4) it.value_length = LEN_ONE;
    else if (pick < 9) it.value_length = LEN_TWO_PLUS;
    else it.value_length = LEN_CODE3;
    it.first_char  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(32, 127))
                                                : 8'($urandom_range(0, 255));
    it.second_char = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 127))
                                                : 8'($urandom_range(0, 255));
    it.compare_op  = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(0, 3))
                                                : 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic send_beat(in_t beat);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver: random stall after each result beat, with stretches of none
  initial begin
    int unsigned hold;
    int unsigned taken;
    bit          quiet_rx;
    out_ready_i = 1'b0;
    hold        = 0;
    taken       = 0;
    quiet_rx    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        taken++;
        if (taken % 32 == 0) quiet_rx = ($urandom_range(0, 2) == 0);
        hold = quiet_rx ? 0 : $urandom_range(0, 10);
        if (hold != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (hold == 0) out_ready_i <= 1'b1;
        else hold--;
      end
    end
  end

  initial begin
    int unsigned k;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet_tx   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // queries before anything is counted
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd65, 8'd66, CMP_GT));
    send_beat(make_item(OP_QUERY, LEN_ONE, 8'd255, 8'd0, CMP_UNKNOWN));
    send_beat(make_item(OP_QUERY, LEN_EMPTY, 8'd0, 8'd255, CMP_EQ));
    // adds at the field extremes, clamped chars and length code three
    send_beat(make_item(OP_ADD, LEN_EMPTY, 8'd90, 8'd255, CMP_LIKE));
    send_beat(make_item(OP_ADD, LEN_ONE, 8'd65, 8'd0, CMP_GT));
    send_beat(make_item(OP_ADD, LEN_TWO_PLUS, 8'd0, 8'd255, CMP_UNKNOWN));
    send_beat(make_item(OP_ADD, LEN_CODE3, 8'd255, 8'd0, CMP_GT));
    send_beat(make_item(OP_ADD, LEN_ONE, 8'd32, 8'd32, CMP_LT));
    send_beat(make_item(OP_ADD, LEN_TWO_PLUS, 8'd127, 8'd127, CMP_LE));
    send_beat(make_item(OP_ADD, LEN_ONE, 8'd128, 8'd128, CMP_NE));
    send_beat(make_item(OP_ADD, LEN_TWO_PLUS, 8'd65, 8'd122, CMP_EQ));
    // every comparison, lengths and second-char clamping
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd65, 8'd122, CMP_GT));
    send_beat(make_item(OP_QUERY, LEN_ONE, 8'd0, 8'd0, CMP_GE));
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd255, 8'd255, CMP_LT));
    send_beat(make_item(OP_QUERY, LEN_CODE3, 8'd127, 8'd0, CMP_LE));
    send_beat(make_item(OP_QUERY, LEN_ONE, 8'd65, 8'd65, CMP_EQ));
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd66, 8'd66, CMP_NE));
    send_beat(make_item(OP_QUERY, LEN_ONE, 8'd67, 8'd67, CMP_LIKE));
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd68, 8'd68, CMP_UNKNOWN));
    send_beat(make_item(OP_QUERY, LEN_EMPTY, 8'd70, 8'd70, CMP_LT));
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd65, 8'd31, CMP_GT));
    send_beat(make_item(OP_QUERY, LEN_TWO_PLUS, 8'd65, 8'd200, CMP_LE));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
      send_beat(random_item());
    end
    in_valid_i <= 1'b0;

    // the checker's pending count is registered, so it trails the last beat
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
